[rtl/hlcfc_pkg.sv]
// Types, codes and the CRC-16 byte update for the header/length/CRC-16 frame checker.
package hlcfc_pkg;

  localparam logic [7:0]  HDR_FIRST  = 8'h3A;
  localparam logic [7:0]  HDR_SECOND = 8'h2E;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [7:0]  LEN_CRC    = 8'd2;

  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC_HI  = 3'd4,
    PH_CRC_LO  = 3'd5,
    PH_DONE    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    V_OK      = 3'd0,
    V_CRC_BAD = 3'd1,
    V_NO_HDR  = 3'd2,
    V_LEN_LOW = 3'd3,
    V_TRUNC   = 3'd4
  } verdict_t;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } rx_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [2:0] verdict;
    logic       last;
  } res_item_t;

  // Step output toward the result queue.
  typedef struct packed {
    logic [1:0] count;
    res_item_t  first;
    res_item_t  second;
  } push_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic res_item_t verdict_item(input verdict_t v);
    res_item_t r;
    r.kind         = KIND_VERDICT;
    r.payload_byte = 8'h00;
    r.verdict      = v;
    r.last         = 1'b1;
    return r;
  endfunction

endpackage

[rtl/hlcfc_step.sv]
// Frame parser state and per-byte step logic: header hunt, length, payload CRC, verdicts.
module hlcfc_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  input  hlcfc_pkg::rx_item_t item,
  output hlcfc_pkg::push_t    push
);
  import hlcfc_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  crc_high_byte, crc_high_byte_next;

  logic [7:0]  b;
  logic [15:0] got;
  logic        emitted;
  res_item_t   r0, r1;
  res_item_t   end_res;
  logic        end_emit;

  assign b   = item.rx_byte;
  assign got = {crc_high_byte, b};

  always_comb begin
    phase_next         = phase;
    running_crc_next   = running_crc;
    bytes_left_next    = bytes_left;
    crc_high_byte_next = crc_high_byte;
    emitted            = 1'b0;
    r0                 = '0;
    r1                 = '0;
    end_emit           = 1'b0;
    end_res            = '0;

    case (phase)
      PH_HUNT1: begin
        if (b == HDR_FIRST) phase_next = PH_HUNT2;
      end
      PH_HUNT2: begin
        if (b == HDR_SECOND) phase_next = PH_LEN;
        else if (b != HDR_FIRST) phase_next = PH_HUNT1;
      end
      PH_LEN: begin
        if (b < LEN_CRC) begin
          r0         = verdict_item(V_LEN_LOW);
          emitted    = 1'b1;
          phase_next = PH_DONE;
        end else begin
          bytes_left_next = b - LEN_CRC;
          phase_next      = (b == LEN_CRC) ? PH_CRC_HI : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        r0.kind          = KIND_PAYLOAD;
        r0.payload_byte  = b;
        emitted          = 1'b1;
        running_crc_next = crc_fold(running_crc, b);
        bytes_left_next  = bytes_left - 8'd1;
        if (bytes_left == 8'd1) phase_next = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        crc_high_byte_next = b;
        phase_next         = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        r0         = verdict_item((got == running_crc) ? V_OK : V_CRC_BAD);
        emitted    = 1'b1;
        phase_next = PH_DONE;
      end
      default: begin
      end
    endcase

    if (item.buffer_end) begin
      case (phase_next)
        PH_HUNT1, PH_HUNT2: begin
          end_emit = 1'b1;
          end_res  = verdict_item(V_NO_HDR);
        end
        PH_LEN, PH_PAYLOAD, PH_CRC_HI, PH_CRC_LO: begin
          end_emit = 1'b1;
          end_res  = verdict_item(V_TRUNC);
        end
        default: begin
        end
      endcase
      if (end_emit) begin
        if (emitted) r1 = end_res;
        else r0 = end_res;
      end
      phase_next         = PH_HUNT1;
      running_crc_next   = CRC_INIT;
      bytes_left_next    = 8'd0;
      crc_high_byte_next = 8'd0;
    end

    push.count  = valid ? ({1'b0, emitted} + {1'b0, end_emit}) : 2'd0;
    push.first  = r0;
    push.second = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT1;
      running_crc   <= CRC_INIT;
      bytes_left    <= 8'd0;
      crc_high_byte <= 8'd0;
    end else if (valid) begin
      phase         <= phase_next;
      running_crc   <= running_crc_next;
      bytes_left    <= bytes_left_next;
      crc_high_byte <= crc_high_byte_next;
    end
  end

endmodule

[rtl/hlcfc_queue.sv]
// Four-entry result queue: up to two pushes and one pop per cycle, head at entry zero.
module hlcfc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  hlcfc_pkg::push_t     push,
  input  logic                 pop,
  output hlcfc_pkg::res_item_t head,
  output logic [2:0]           count
);
  import hlcfc_pkg::*;

  localparam int DEPTH = 4;

  res_item_t   entry [DEPTH];
  res_item_t   entry_next [DEPTH];
  logic [2:0]  count_next;
  logic [2:0]  base;
  logic [2:0]  base_p1;

  assign head = entry[0];

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (pop && i < DEPTH - 1) entry_next[i] = entry[i + 1];
      else entry_next[i] = entry[i];
    end
    base    = count - {2'b00, pop};
    base_p1 = base + 3'd1;
    if (push.count != 2'd0) entry_next[base[1:0]] = push.first;
    if (push.count == 2'd2) entry_next[base_p1[1:0]] = push.second;
    count_next = base + {1'b0, push.count};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      entry[i] <= entry_next[i];
    end
  end

endmodule

[rtl/header_length_crc16_frame_checker.sv]
// Top level of the header/length/CRC-16 frame checker.
// Takes one buffer byte per clock while rx_stall is low. Each byte is
// registered, then parsed (header 0x3A 0x2E, length, payload folded into
// CRC-16/0x1021 from 0xFFFF, big-endian CRC compare) and its results go into
// a four-entry result queue. A byte gives zero, one or two results (a payload
// byte on a truncating buffer end gives two); the output drains one result per
// clock while res_stall is low, so rx_stall rises only while the queue cannot
// take the results of the byte in flight plus the worst case of the next one.
// Sustained rate is one byte per clock while res_stall and rx_stall stay low.
// Each buffer ends in exactly one result with last set; payload results come
// first and are to be dropped unless that verdict is ok.
module header_length_crc16_frame_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rx_valid,
  output logic                 rx_stall,
  input  hlcfc_pkg::rx_item_t  rx_item,
  output logic                 res_valid,
  input  logic                 res_stall,
  output hlcfc_pkg::res_item_t res_item
);
  import hlcfc_pkg::*;

  logic       rx_accept;
  logic       held_valid;
  rx_item_t   held;
  push_t      push;
  logic       pop;
  logic [2:0] count;
  logic [3:0] need;

  assign rx_accept = rx_valid && !rx_stall;
  assign need      = {1'b0, count} + {2'b00, push.count} + 4'd2;
  assign rx_stall  = need > 4'd4;
  assign res_valid = count != 3'd0;
  assign pop       = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= rx_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_accept) held <= rx_item;
  end

  hlcfc_step u_step (
    .clk   (clk),
    .rst   (rst),
    .valid (held_valid),
    .item  (held),
    .push  (push)
  );

  hlcfc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (res_item),
    .count (count)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("result queue overfilled");

  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_item.kind == res_item.last))
    else $error("verdict result without last, or payload result with last");

  a_end_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    (held_valid && held.buffer_end && push.count == 2'd2) |->
    (push.second.last && !push.first.last))
    else $error("two results on buffer end not payload then verdict");

  a_pop_advances: assert property (@(posedge clk) disable iff (rst)
    (pop && push.count == 2'd0) |=> count == $past(count) - 3'd1)
    else $error("queue count did not follow a pop");

endmodule

[tb/header_length_crc16_frame_checker_tb.sv]
`timescale 1ns / 100ps
// Testbench for header_length_crc16_frame_checker: directed and random buffers against a predictor.
module header_length_crc16_frame_checker_tb;
  import hlcfc_pkg::*;

  localparam int QUIET_LIMIT = 3000;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      rx_valid  = 1'b0;
  logic      rx_stall;
  rx_item_t  rx_item   = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_item_t res_item;

  int        send_gap_pct = 0;
  int        stall_pct    = 0;
  int        error_count  = 0;
  int        bytes_sent   = 0;
  int        quiet_cycles = 0;

  phase_t     frame_phase  = PH_HUNT1;
  logic [15:0] frame_crc   = CRC_INIT;
  logic [7:0] payload_left = 8'd0;
  logic [7:0] crc_msb      = 8'd0;

  res_item_t  pending_results[$];
  res_item_t  oldest_result;
  logic [7:0] frame_bytes[$];

  header_length_crc16_frame_checker dut (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx_item  (rx_item),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_item (res_item)
  );

  always #5 clk = ~clk;

  // bitwise CRC-16, poly 0x1021, MSB first
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[15] ^ b[i];
      crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return crc;
  endfunction

  function automatic void push_verdict(input verdict_t v);
    res_item_t r;
    r.kind         = KIND_VERDICT;
    r.payload_byte = 8'h00;
    r.verdict      = v;
    r.last         = 1'b1;
    pending_results.push_back(r);
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b, input logic at_end);
    res_item_t r;
    case (frame_phase)
      PH_HUNT1: begin
        if (b == HDR_FIRST) frame_phase = PH_HUNT2;
      end
      PH_HUNT2: begin
        if (b == HDR_SECOND) frame_phase = PH_LEN;
        else if (b != HDR_FIRST) frame_phase = PH_HUNT1;
      end
      PH_LEN: begin
        if (b < LEN_CRC) begin
          push_verdict(V_LEN_LOW);
          frame_phase = PH_DONE;
        end else begin
          payload_left = b - LEN_CRC;
          frame_phase  = (payload_left == 8'd0) ? PH_CRC_HI : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        r.kind         = KIND_PAYLOAD;
        r.payload_byte = b;
        r.verdict      = V_OK;
        r.last         = 1'b0;
        pending_results.push_back(r);
        frame_crc    = crc16_update(frame_crc, b);
        payload_left = payload_left - 8'd1;
        if (payload_left == 8'd0) frame_phase = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        crc_msb     = b;
        frame_phase = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        push_verdict(({crc_msb, b} == frame_crc) ? V_OK : V_CRC_BAD);
        frame_phase = PH_DONE;
      end
      default: ;
    endcase
    if (at_end) begin
      if (frame_phase == PH_HUNT1 || frame_phase == PH_HUNT2) push_verdict(V_NO_HDR);
      else if (frame_phase != PH_DONE) push_verdict(V_TRUNC);
      frame_phase  = PH_HUNT1;
      frame_crc    = CRC_INIT;
      payload_left = 8'd0;
      crc_msb      = 8'd0;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic at_end);
    while ($urandom_range(99) < send_gap_pct) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    rx_valid           <= 1'b1;
    rx_item.rx_byte    <= b;
    rx_item.buffer_end <= at_end;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    parse_rx_byte(b, at_end);
    bytes_sent++;
  endtask

  task automatic send_buffer();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic check_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h", $time, res_item);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("kind", oldest_result.kind, res_item.kind);
        check_field("payload_byte", oldest_result.payload_byte, res_item.payload_byte);
        check_field("verdict", oldest_result.verdict, res_item.verdict);
        check_field("last", oldest_result.last, res_item.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((rx_valid && !rx_stall) || (res_valid && !res_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("status: fail");
      $finish;
    end
  end

  // repeated first header byte, zero length, ignored tail, header cut after 0x2E
  task automatic test_header_search();
    frame_bytes = '{8'h3A, 8'h41, 8'h2E};
    send_buffer();
    frame_bytes = '{8'h3A, 8'h3A, 8'h2E, 8'h00, 8'hFF};
    send_buffer();
    frame_bytes = '{8'h3A, 8'h2E};
    send_buffer();
  endtask

  task automatic test_length_limits();
    frame_bytes = '{8'h3A, 8'h2E, 8'h01};
    send_buffer();
    frame_bytes = '{8'h3A, 8'h2E, 8'h02, 8'hFF, 8'hFF};
    send_buffer();
  endtask

  task automatic test_truncation();
    frame_bytes = '{8'h3A, 8'h2E, 8'h05, 8'h00, 8'hFF};
    send_buffer();
  endtask

  task automatic test_crc_mismatch();
    frame_bytes = '{8'h3A, 8'h2E, 8'h03, 8'hA5, 8'h00, 8'h00};
    send_buffer();
  endtask

  task automatic build_frame();
    int          plen;
    logic [15:0] crc;
    crc = CRC_INIT;
    plen = ($urandom_range(19) == 0) ? $urandom_range(253) : $urandom_range(8);
    repeat ($urandom_range(2)) frame_bytes.push_back(8'($urandom_range(255)));
    frame_bytes.push_back(HDR_FIRST);
    frame_bytes.push_back(HDR_SECOND);
    frame_bytes.push_back(8'(plen + 2));
    repeat (plen) begin
      frame_bytes.push_back(8'($urandom_range(255)));
      crc = crc16_update(crc, frame_bytes[$]);
    end
    if ($urandom_range(3) == 0) crc = crc ^ 16'($urandom_range(1, 65535));
    frame_bytes.push_back(crc[15:8]);
    frame_bytes.push_back(crc[7:0]);
    repeat ($urandom_range(2)) frame_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic test_random_buffers(input int item_count);
    int stop_at;
    int shape;
    stop_at = bytes_sent + item_count;
    while (bytes_sent < stop_at) begin
      frame_bytes.delete();
      shape = $urandom_range(9);
      if (shape <= 7) begin
        build_frame();
        if (shape == 7) begin
          repeat ($urandom_range(1, frame_bytes.size() - 1)) void'(frame_bytes.pop_back());
        end
      end else if (shape == 8) begin
        frame_bytes = '{HDR_FIRST, HDR_SECOND};
        frame_bytes.push_back(8'($urandom_range(1)));
        repeat ($urandom_range(2)) frame_bytes.push_back(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 6))
          frame_bytes.push_back(($urandom_range(3) == 0) ? HDR_FIRST : 8'($urandom_range(255)));
      end
      send_buffer();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    send_gap_pct = 8;
    stall_pct    = 47;
    test_header_search();
    test_length_limits();
    test_truncation();
    test_crc_mismatch();
    test_random_buffers(275);
    send_gap_pct = 47;
    stall_pct    = 8;
    test_random_buffers(275);
    send_gap_pct = 0;
    stall_pct    = 0;
    test_random_buffers(275);
    rx_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
